/* design/nket_pkg.sv */
// ----------------------------------------------------------------------------
// nket_pkg
// shared types and constants for the name keyed entry table
// ----------------------------------------------------------------------------
package nket_pkg;

	localparam int IDX_MAX_W = 10;
	localparam int KEY_MAX_W = 64;
	localparam int LOC_W     = 16;
	localparam int OUT_IDX_W = 6;

	typedef enum logic [1:0] {
		KIND_FIND   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_PRESENT   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// request held for the whole scan, broadcast to every cell
	typedef struct packed {
		kind_t                  kind;
		logic [KEY_MAX_W-1:0]   key;
		logic [LOC_W-1:0]       loc;
		logic                   dir;
	} req_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic                   active;
		logic                   found;
		logic [IDX_MAX_W-1:0]   match_idx;
		logic [LOC_W-1:0]       match_loc;
		logic                   free_found;
		logic [IDX_MAX_W-1:0]   free_idx;
	} tok_t;

	// entry fill command
	typedef struct packed {
		logic                   en;
		logic [IDX_MAX_W-1:0]   idx;
	} wr_t;

endpackage

/* design/nket_if.sv */
// ----------------------------------------------------------------------------
// nket_req_if / nket_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface nket_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] name_key;
	logic [15:0] location;
	logic        is_directory;

	modport source (output valid, kind, name_key, location, is_directory, input ready);
	modport sink   (input valid, kind, name_key, location, is_directory, output ready);
endinterface

interface nket_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] found_location;
	logic [5:0]  entry_index;

	modport source (output valid, status, found_location, entry_index, input ready);
	modport sink   (input valid, status, found_location, entry_index, output ready);
endinterface

/* design/name_keyed_entry_table.sv */
// ----------------------------------------------------------------------------
// name_keyed_entry_table
// fixed table of named entries with find, add and remove requests
// ----------------------------------------------------------------------------
// req carries one request word (kind, name_key, location, is_directory);
// rsp returns exactly one result word per request (status, found_location,
// entry_index). Every entry sits in a cell of a chain; a request launches a
// token that walks the chain one cell per cycle, collecting the lowest
// matching entry and the lowest free entry. Remove clears the matching cell
// as the token passes; add fills the free cell once the walk has ended.
// The time from acceptance to the result in the output register is set by
// the walk over the chain; req.ready is high only while no request is in
// flight, so the next request is taken only after the result of the last
// has been loaded into the output register.
// A result waiting in the output register does not block the next request;
// a further result is held back until rsp.ready frees the register.
// Reset clears all valid marks and the token chain at once; no request is
// lost or duplicated under any stall pattern.
// ----------------------------------------------------------------------------
module name_keyed_entry_table #(
	parameter int ENTRIES    = 64,
	parameter int NAME_CHARS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	nket_req_if.sink          req,
	nket_rsp_if.source        rsp
);
	import nket_pkg::*;

	localparam int KEY_W = 8 * NAME_CHARS;

	state_t                 state_q;
	state_t                 state_d;
	req_t                   req_q;
	logic                   launch_q;
	tok_t                   fin_q;
	tok_t                   chain [ENTRIES+1];
	wr_t                    wr;
	logic                   in_acc;
	logic                   load;
	status_t                res_status;
	logic [LOC_W-1:0]       res_loc;
	logic [IDX_MAX_W-1:0]   res_idx;
	logic                   rsp_valid_q;
	status_t                rsp_status_q;
	logic [LOC_W-1:0]       rsp_loc_q;
	logic [OUT_IDX_W-1:0]   rsp_idx_q;
	logic [IDX_MAX_W+OUT_IDX_W-1:0] idx_ext;

	assign in_acc = req.valid && req.ready;

	always_comb begin
		chain[0]        = '0;
		chain[0].active = launch_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		nket_cell #(
			.KEY_W     (KEY_W),
			.ENTRY_IDX (IDX_MAX_W'(i))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req_q),
			.wr      (wr),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (chain[ENTRIES].active) state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		load      = 1'b0;
		case (state_q)
			S_IDLE:  req.ready = 1'b1;
			S_DONE:  load      = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				load      = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_status = ST_NOT_FOUND;
		res_loc    = '0;
		res_idx    = '0;
		wr.en      = 1'b0;
		wr.idx     = fin_q.free_idx;
		case (req_q.kind)
			KIND_FIND: begin
				if (fin_q.found) begin
					res_status = ST_OK;
					res_loc    = fin_q.match_loc;
					res_idx    = fin_q.match_idx;
				end
			end
			KIND_ADD: begin
				if (fin_q.found) begin
					res_status = ST_PRESENT;
				end else if (fin_q.free_found) begin
					res_status = ST_OK;
					res_idx    = fin_q.free_idx;
					wr.en      = load;
				end else begin
					res_status = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (fin_q.found) begin
					res_status = ST_OK;
					res_idx    = fin_q.match_idx;
				end
			end
			default: res_status = ST_NOT_FOUND;
		endcase
	end

	assign idx_ext = {{OUT_IDX_W{1'b0}}, res_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= in_acc;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q.kind <= kind_t'(req.kind);
			req_q.key  <= req.name_key;
			req_q.loc  <= req.location;
			req_q.dir  <= req.is_directory;
		end
		if (state_q == S_SCAN && chain[ENTRIES].active) begin
			fin_q <= chain[ENTRIES];
		end
		if (load) begin
			rsp_status_q <= res_status;
			rsp_loc_q    <= res_loc;
			rsp_idx_q    <= idx_ext[OUT_IDX_W-1:0];
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.found_location = rsp_loc_q;
	assign rsp.entry_index    = rsp_idx_q;

endmodule

/* design/nket_cell.sv */
// ----------------------------------------------------------------------------
// nket_cell
// one table entry; compares the passing scan token and hands it on
// ----------------------------------------------------------------------------
module nket_cell #(
	parameter int                         KEY_W     = 64,
	parameter logic [9:0]                 ENTRY_IDX = 10'd0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nket_pkg::req_t req,
	input  nket_pkg::wr_t  wr,
	input  nket_pkg::tok_t tok_in,
	output nket_pkg::tok_t tok_out
);
	import nket_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [LOC_W-1:0]  loc_q;
	logic              dir_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic              hit;
	logic              first_hit;
	logic              wr_sel;

	assign hit       = valid_q && (key_q == req.key[KEY_W-1:0]);
	assign first_hit = tok_in.active && hit && !tok_in.found;
	assign wr_sel    = wr.en && (wr.idx == ENTRY_IDX);

	always_comb begin
		tok_d = tok_in;
		if (first_hit) begin
			tok_d.found     = 1'b1;
			tok_d.match_idx = ENTRY_IDX;
			tok_d.match_loc = loc_q;
		end
		if (tok_in.active && !valid_q && !tok_in.free_found) begin
			tok_d.free_found = 1'b1;
			tok_d.free_idx   = ENTRY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_d;
			if (wr_sel) begin
				valid_q <= 1'b1;
			end else if (first_hit && req.kind == KIND_REMOVE) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			key_q <= req.key[KEY_W-1:0];
			loc_q <= req.loc;
			dir_q <= req.dir;
		end
	end

	assign tok_out = tok_q;

endmodule

/* design/nket_chk.sv */
// ----------------------------------------------------------------------------
// nket_chk
// port-level checks on the name keyed entry table
// ----------------------------------------------------------------------------
module nket_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  out_status,
	input  logic [15:0] out_location,
	input  logic [5:0]  out_index
);
	import nket_pkg::*;

	// a failed request reports zero location and index
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status != ST_OK) |-> (out_location == '0 && out_index == '0))
		else $error("failed result with nonzero location or index");

	// only one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_status)
			&& $stable(out_location) && $stable(out_index)))
		else $error("stalled result word changed");

	// no result right after a reset cycle
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");

endmodule

bind name_keyed_entry_table nket_chk u_nket_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.out_status   (rsp.status),
	.out_location (rsp.found_location),
	.out_index    (rsp.entry_index)
);

/* test/name_keyed_entry_table_tb.sv */
// ----------------------------------------------------------------------------
// name_keyed_entry_table_tb
// self-checking testbench for the name keyed entry table
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the table and works out the
// answer to every request word taken by the block. Answer words are compared
// field by field, in order. A short directed run covers the empty table,
// the all-zero and all-one keys, duplicate adds, remove and re-add into the
// lowest free slot, keys with bytes after a zero byte and the unused kind.
// Random runs follow, first filling the table up to full and then draining
// it, under four mixes of sender gaps and receiver stalls. One of these
// holds the receiver off for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module name_keyed_entry_table_tb;
	import nket_pkg::*;

	localparam int ENTRIES = 64;
	localparam int POOL_SIZE = 96;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_MAX = 10;
	localparam int SRC_IDLE[4] = '{0, 76, 0, 22};
	localparam int SNK_STALL[4] = '{0, 0, 76, 22};
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_AB = 64'h0000_0000_0000_6261;
	localparam logic [63:0] KEY_AB_TAIL = 64'h0000_0000_7800_6261;
	localparam logic [63:0] KEY_SAM = 64'h0000_0000_006D_6173;

	typedef struct packed {
		status_t                st;
		logic [LOC_W-1:0]       loc;
		logic [OUT_IDX_W-1:0]   idx;
	} answer_t;

	class entry_table_scoreboard;
		bit                     occupied[ENTRIES];
		logic [KEY_MAX_W-1:0]   names[ENTRIES];
		logic [LOC_W-1:0]       places[ENTRIES];
		answer_t                awaited[$];
		int                     answers;
		int                     mismatches;
		int                     strays;
		int                     status_seen[4];

		function int lowest_match(logic [KEY_MAX_W-1:0] key);
			for (int i = 0; i < ENTRIES; i++)
				if (occupied[i] && names[i] == key)
					return i;
			return -1;
		endfunction

		function int lowest_free();
			for (int i = 0; i < ENTRIES; i++)
				if (!occupied[i])
					return i;
			return -1;
		endfunction

		function void note_request(logic [1:0] kind, logic [KEY_MAX_W-1:0] key,
				logic [LOC_W-1:0] loc);
			answer_t a;
			int hit;
			int slot;
			a.st = ST_NOT_FOUND;
			a.loc = '0;
			a.idx = '0;
			hit = lowest_match(key);
			case (kind)
			KIND_FIND: begin
				if (hit >= 0) begin
					a.st = ST_OK;
					a.loc = places[hit];
					a.idx = hit[OUT_IDX_W-1:0];
				end
			end
			KIND_ADD: begin
				if (hit >= 0) begin
					a.st = ST_PRESENT;
				end else begin
					slot = lowest_free();
					if (slot < 0) begin
						a.st = ST_FULL;
					end else begin
						occupied[slot] = 1'b1;
						names[slot] = key;
						places[slot] = loc;
						a.st = ST_OK;
						a.idx = slot[OUT_IDX_W-1:0];
					end
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					occupied[hit] = 1'b0;
					a.st = ST_OK;
					a.idx = hit[OUT_IDX_W-1:0];
				end
			end
			default: ;
			endcase
			awaited.push_back(a);
		endfunction

		function void check_answer(logic [1:0] st, logic [LOC_W-1:0] loc,
				logic [OUT_IDX_W-1:0] idx);
			answer_t e;
			answers++;
			if (awaited.size() == 0) begin
				strays++;
				if (strays + mismatches <= REPORT_MAX)
					$display("unexpected answer word: status %0d location %h index %0d",
						st, loc, idx);
				return;
			end
			e = awaited.pop_front();
			status_seen[e.st]++;
			if (st !== e.st || loc !== e.loc || idx !== e.idx) begin
				mismatches++;
				if (strays + mismatches <= REPORT_MAX)
					$display("answer %0d: expected status %0d location %h index %0d, got status %0d location %h index %0d",
						answers, e.st, e.loc, e.idx, st, loc, idx);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	nket_req_if req_ch();
	nket_rsp_if rsp_ch();

	entry_table_scoreboard expected_table;
	int src_idle_pct;
	int snk_stall_pct;
	bit rsp_hold;
	int quiet_cycles;
	int sent;
	int failures;
	logic [63:0] name_pool[POOL_SIZE];

	name_keyed_entry_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			expected_table.check_answer(rsp_ch.status, rsp_ch.found_location,
				rsp_ch.entry_index);
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL name_keyed_entry_table");
			$finish;
		end
	end

	task automatic offer_request(logic [1:0] kind, logic [63:0] key, logic [15:0] loc,
			logic dir);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.name_key <= key;
		req_ch.location <= loc;
		req_ch.is_directory <= dir;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_table.note_request(kind, key, loc);
		sent++;
	endtask

	function automatic logic [63:0] random_name();
		logic [63:0] k;
		int len;
		k = '0;
		if ($urandom_range(3) == 0) begin
			k = {$urandom, $urandom};
		end else begin
			len = $urandom_range(8, 1);
			for (int c = 0; c < len; c++)
				k[8*c +: 8] = 8'($urandom_range(126, 33));
		end
		return k;
	endfunction

	task automatic run_random(int count, int add_pct, int remove_pct);
		logic [1:0] kind;
		logic [63:0] key;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < add_pct)
				kind = KIND_ADD;
			else if (roll < add_pct + remove_pct)
				kind = KIND_REMOVE;
			else if (roll < 95)
				kind = KIND_FIND;
			else
				kind = KIND_UNUSED;
			if ($urandom_range(9) == 0)
				key = {$urandom, $urandom};
			else
				key = name_pool[$urandom_range(POOL_SIZE - 1)];
			offer_request(kind, key, 16'($urandom), 1'($urandom));
		end
	endtask

	task automatic hold_results(int cycles);
		rsp_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		rsp_hold = 1'b0;
	endtask

	initial begin
		expected_table = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_FIND;
		req_ch.name_key = '0;
		req_ch.location = '0;
		req_ch.is_directory = 1'b0;
		rsp_ch.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		rsp_hold = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			name_pool[i] = random_name();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer_request(KIND_FIND, KEY_ONES, 16'hFFFF, 1'b1);
		offer_request(KIND_REMOVE, KEY_ONES, 16'h0000, 1'b0);
		offer_request(KIND_UNUSED, 64'd0, 16'h5A5A, 1'b1);
		offer_request(KIND_ADD, 64'd0, 16'h0000, 1'b0);
		offer_request(KIND_ADD, KEY_ONES, 16'hFFFF, 1'b1);
		offer_request(KIND_ADD, 64'd0, 16'h1111, 1'b1);
		offer_request(KIND_FIND, 64'd0, 16'hFFFF, 1'b1);
		offer_request(KIND_FIND, KEY_ONES, 16'h0000, 1'b0);
		offer_request(KIND_ADD, KEY_AB_TAIL, 16'h1234, 1'b0);
		offer_request(KIND_FIND, KEY_AB, 16'h0000, 1'b0);
		offer_request(KIND_ADD, KEY_AB, 16'h8001, 1'b1);
		offer_request(KIND_FIND, KEY_AB_TAIL, 16'h0000, 1'b0);
		offer_request(KIND_REMOVE, KEY_ONES, 16'h0000, 1'b0);
		offer_request(KIND_FIND, KEY_ONES, 16'h0000, 1'b0);
		offer_request(KIND_ADD, KEY_SAM, 16'h4321, 1'b1);
		offer_request(KIND_UNUSED, KEY_SAM, 16'h0000, 1'b0);
		offer_request(KIND_FIND, KEY_SAM, 16'h0000, 1'b0);
		offer_request(KIND_REMOVE, 64'd0, 16'hFFFF, 1'b1);
		offer_request(KIND_REMOVE, 64'd0, 16'h0000, 1'b0);
		offer_request(KIND_FIND, 64'd0, 16'h0000, 1'b0);

		for (int p = 0; p < 4; p++) begin
			src_idle_pct = SRC_IDLE[p];
			snk_stall_pct = SNK_STALL[p];
			run_random(165, 65, 10);
			run_random(165, 15, 60);
			if (p == 0) begin
				fork
					hold_results(HOLD_CYCLES);
					run_random(30, 50, 20);
				join
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_table.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request words sent, %0d answers checked, four stall mixes plus a long hold-off",
			sent, expected_table.answers);
		$display("answers seen: ok %0d, not found %0d, already present %0d, table full %0d",
			expected_table.status_seen[ST_OK], expected_table.status_seen[ST_NOT_FOUND],
			expected_table.status_seen[ST_PRESENT], expected_table.status_seen[ST_FULL]);
		failures = expected_table.mismatches + expected_table.strays
			+ expected_table.awaited.size();
		if (failures == 0)
			$display("PASS name_keyed_entry_table");
		else
			$display("FAIL name_keyed_entry_table");
		$finish;
	end

endmodule

/* name_keyed_entry_table.f */
design/nket_pkg.sv
design/nket_if.sv
design/nket_cell.sv
design/name_keyed_entry_table.sv
design/nket_chk.sv
test/name_keyed_entry_table_tb.sv
